FILE: rtl/bole_pkg.sv
// Shared types and codes for the bounded ordered list engine.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package bole_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 7;   // width of the entry_count result field

  typedef enum logic [1:0] {
    CMD_APPEND    = 2'd0,
    CMD_DELETE    = 2'd1,
    CMD_DROP_LAST = 2'd2,
    CMD_REPORT    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_SCAN,
    WS_HOLD
  } walk_state_t;

  // Command handed from the front end to the walker.
  typedef struct packed {
    logic                    start;
    cmd_t                    cmd;
    logic signed [DataW-1:0] value;
  } req_t;

  // Result handed back from the walker (count travels beside it).
  typedef struct packed {
    logic                    valid;
    status_t                 status;
    logic signed [DataW-1:0] max_value;
    logic                    empty;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/bole_store.sv
// Entry store: one write port, one read port, read data registered.
// Depends on bole_pkg for the data width.
`default_nettype none

module bole_store
  import bole_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic signed [DataW-1:0] wdata,
  input  wire logic [AW-1:0]           raddr,
  output      logic signed [DataW-1:0] rdata
);

  logic signed [DataW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/bole_walk.sv
// Walker: per command, one pass over the stored entries through the store's
// read port; finds and closes the gap on delete and tracks the maximum.
// Depends on bole_pkg; drives the ports of bole_store.
`default_nettype none

module bole_walk
  import bole_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire req_t                    req,
  input  wire logic [CW-1:0]           count,
  input  wire logic                    rsp_ready,
  output      res_t                    rsp,
  output      logic [CW-1:0]           rsp_count,
  output      logic                    mem_we,
  output      logic [AW-1:0]           mem_waddr,
  output      logic signed [DataW-1:0] mem_wdata,
  output      logic [AW-1:0]           mem_raddr,
  input  wire logic signed [DataW-1:0] mem_rdata
);

  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
  localparam logic [CW-1:0] OneCount = CW'(1);
  localparam logic [AW-1:0] OneAddr  = AW'(1);

  walk_state_t state, state_next;

  cmd_t                    cmd_q;
  logic signed [DataW-1:0] value_q;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           len;
  logic [CW-1:0]           ptr;
  logic                    dvalid;
  logic [AW-1:0]           rpos;
  logic                    found;
  logic                    have;
  logic signed [DataW-1:0] maxv;

  logic hit;
  logic full;
  logic issue;
  logic scan_end;

  assign full     = (count_q == CapCount);
  assign issue    = (state == WS_SCAN) && (ptr < len);
  assign scan_end = (ptr == len) && !dvalid;
  assign hit      = dvalid && (cmd_q == CMD_DELETE) && !found && (mem_rdata == value_q);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      WS_IDLE: if (req.start) state_next = WS_SCAN;
      WS_SCAN: if (scan_end)  state_next = WS_HOLD;
      WS_HOLD: if (rsp_ready) state_next = WS_IDLE;
      default: state_next = WS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rpos - OneAddr;
    mem_wdata = mem_rdata;
    mem_raddr = ptr[AW-1:0];
    rsp       = '0;
    rsp_count = count_q;
    unique case (state)
      WS_IDLE: begin
        // append goes straight to the tail slot
        if (req.start && (req.cmd == CMD_APPEND) && (count != CapCount)) begin
          mem_we    = 1'b1;
          mem_waddr = count[AW-1:0];
          mem_wdata = req.value;
        end
      end
      WS_SCAN: begin
        // shift down every entry read after the deleted one
        mem_we = dvalid && found;
      end
      WS_HOLD: begin
        rsp.valid     = 1'b1;
        rsp.status    = STAT_DONE;
        rsp.max_value = have ? maxv : '0;
        unique case (cmd_q)
          CMD_APPEND: begin
            if (full) begin
              rsp.status = STAT_FULL;
            end else begin
              rsp_count = count_q + OneCount;
              if (!have || (value_q > maxv)) rsp.max_value = value_q;
            end
          end
          CMD_DELETE: begin
            if (found) rsp_count = count_q - OneCount;
            else       rsp.status = STAT_MISSING;
          end
          CMD_DROP_LAST: begin
            if (count_q == '0) rsp.status = STAT_MISSING;
            else               rsp_count = count_q - OneCount;
          end
          CMD_REPORT: ;
          default: ;
        endcase
        rsp.empty = (rsp_count == '0);
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= 1'b0;
      ptr    <= '0;
    end else begin
      dvalid <= issue;
      if (state == WS_IDLE && req.start) begin
        ptr <= '0;
      end else if (issue) begin
        ptr <= ptr + OneCount;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == WS_IDLE && req.start) begin
      cmd_q   <= req.cmd;
      value_q <= req.value;
      count_q <= count;
      found   <= 1'b0;
      have    <= 1'b0;
      // drop-last leaves the tail out of the max walk
      if (req.cmd == CMD_DROP_LAST && count != '0) len <= count - OneCount;
      else                                           len <= count;
    end else begin
      if (issue) rpos <= ptr[AW-1:0];
      if (hit) begin
        found <= 1'b1;
      end else if (dvalid && (!have || (mem_rdata > maxv))) begin
        have <= 1'b1;
        maxv <= mem_rdata;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bounded_ordered_list_engine_unit.sv
// Top level of the bounded ordered list engine: front-end handshake, entry
// count register and output register. Depends on bole_pkg, bole_store, bole_walk.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values and
// answers every command beat with exactly one result beat (status, entry
// count, largest value, empty flag). Commands: append at the tail, delete the
// first matching value and close the gap, drop the last entry, report only.
// An append to a full list is dropped with status "full". One command is in
// work at a time. For each command the walker reads the entries held before
// it (all but the last entry for drop-last) from the entry store through its
// single read port, one entry per cycle, while doing search,
// gap closing and the maximum in that same pass. A finished result sits in
// the output register, so the next command beat can be taken while it waits
// for the consumer. No clearing pass is needed after reset: only entries below
// the count are ever read.
`default_nettype none

module bounded_ordered_list_engine_unit
  import bole_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire logic [1:0]              cmd,
  input  wire logic signed [DataW-1:0] value,
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      logic [1:0]              status,
  output      logic [CountW-1:0]       entry_count,
  output      logic signed [DataW-1:0] max_value,
  output      logic                    list_empty
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  req_t                    req;
  res_t                    rsp;
  logic [CW-1:0]           rsp_count;
  logic                    rsp_ready;
  logic                    busy;
  logic [CW-1:0]           count;
  logic [CW+CountW-1:0]    count_wide;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [DataW-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic signed [DataW-1:0] mem_rdata;

  // Take one command beat at a time; hold off until its result is handed over.
  assign in_stall  = busy;
  assign req.start = in_valid && !busy;
  assign req.cmd   = cmd_t'(cmd);
  assign req.value = value;

  // The output register can take a result when empty or being drained.
  assign rsp_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (rsp.valid && rsp_ready) begin
      busy <= 1'b0;
    end
  end

  // Entry count advances only when a result is handed over.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (rsp.valid && rsp_ready) begin
      count <= rsp_count;
    end
  end

  // Output register: load a finished result, drop the beat once taken.
  assign count_wide = {{CountW{1'b0}}, rsp_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp.valid && rsp_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid && rsp_ready) begin
      status      <= rsp.status;
      entry_count <= count_wide[CountW-1:0];
      max_value   <= rsp.max_value;
      list_empty  <= rsp.empty;
    end
  end

  bole_walk #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .count     (count),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .rsp_count (rsp_count),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bole_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
